FILE: rtl/core/psa_pkg.sv
// shared constants, field layout and codes of the priority scheduler with aging
package psa_pkg;

	localparam int MAX_PROCESSES_DEF = 16;
	localparam int AGING_TICKS_DEF   = 4;

	// at most this many slots take part in one schedule
	localparam int SLOT_LIMIT   = 16;
	localparam int MAX_SEGMENTS = 32;

	localparam int SLOT_W  = 4;
	localparam int ARR_W   = 16;
	localparam int PRI_W   = 4;
	localparam int BURST_W = 12;
	localparam int TIME_W  = 17;
	localparam int COUNT_W = 5;
	localparam int SEG_W   = 6;

	// input tdata: slot, arrival_time, priority_level, burst_length, zero pad
	localparam int IN_DATA_W = 40;
	localparam int ARR_LSB   = SLOT_W;
	localparam int PRI_LSB   = ARR_LSB + ARR_W;
	localparam int BURST_LSB = PRI_LSB + PRI_W;

	// output tdata: process_slot, start_time, end_time, zero pad
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_W + 2 * TIME_W);

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_START = 1'b1
	} func_t;

endpackage

FILE: rtl/core/priority_scheduler_with_aging_core.sv
// non-preemptive priority scheduler with aging: slot table, sequencer and segment output
//
// Load transactions (tuser 0) write one slot of the process table; a start transaction
// (tuser 1) runs the schedule over slots 0 .. process_count-1 (process_count clamped to
// min(MAX_PROCESSES, SLOT_LIMIT)) from tick 0 and emits one output transaction per
// segment, tlast on the final one. The input side is not ready while a transaction is
// being worked on. A load passes through the shared remainder unit (a reciprocal
// multiply for the quotient, then a multiply back and subtract) that yields the arrival
// tick's phase within the aging interval. For each emitted segment a start runs the
// same remainder unit on the current tick, then walks the table one slot a cycle (aging,
// selection and next-arrival search together), then emits the segment, which waits
// while the output side stalls. The output register frees the sequencer as soon as the
// previous segment has been taken.
module priority_scheduler_with_aging_core
	import psa_pkg::*;
#(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
	parameter int AGING_TICKS   = AGING_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_W-1:0]    cfg_data,        // process_count
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,    // slot, arrival_time, priority_level, burst_length
	input  logic                  s_axis_tuser,    // func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,    // process_slot, start_time, end_time
	output logic                  m_axis_tuser,    // is_idle
	output logic                  m_axis_tlast     // last_segment
);

	localparam int IDX_W     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int SCAN_LIM  = (MAX_PROCESSES < SLOT_LIMIT) ? MAX_PROCESSES : SLOT_LIMIT;
	localparam int REM_W     = (AGING_TICKS > 1) ? $clog2(AGING_TICKS) : 1;
	// reciprocal of the aging interval, exact for every tick of TIME_W bits
	localparam int AGE_LOG   = (AGING_TICKS > 1) ? $clog2(AGING_TICKS) : 0;
	localparam int RECIP_SH  = TIME_W + AGE_LOG;
	localparam int RECIP     = ((1 << RECIP_SH) + AGING_TICKS - 1) / AGING_TICKS;
	localparam int PROD_W    = 2 * TIME_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;

	// slot table
	logic [ARR_W-1:0]   arr_q        [MAX_PROCESSES];
	logic [BURST_W-1:0] burst_q      [MAX_PROCESSES];
	logic [PRI_W-1:0]   loaded_pri_q [MAX_PROCESSES];
	logic [PRI_W-1:0]   eff_pri_q    [MAX_PROCESSES];
	logic [REM_W-1:0]   arr_mod_q    [MAX_PROCESSES];
	logic               done_q       [MAX_PROCESSES];

	logic [COUNT_W-1:0] proc_count_q;
	logic [COUNT_W-1:0] n_q;
	logic [COUNT_W-1:0] done_cnt_q;
	logic [COUNT_W-1:0] i_q;
	logic [SEG_W-1:0]   k_q;
	logic [TIME_W-1:0]  time_q;
	logic [REM_W-1:0]   tmod_q;

	logic               best_v_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [PRI_W-1:0]   best_pri_q;
	logic [ARR_W-1:0]   best_arr_q;
	logic [BURST_W-1:0] best_burst_q;
	logic               next_v_q;
	logic [ARR_W-1:0]   next_arr_q;

	// remainder unit
	logic [TIME_W-1:0]    mod_x_q;
	logic [TIME_W-1:0]    mod_quo_q;
	logic                 mod_ph_q;
	logic                 load_mode_q;
	logic [IDX_W-1:0]     load_idx_q;

	// output register
	logic              out_valid_q;
	logic              out_idle_q;
	logic              out_last_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [TIME_W-1:0] out_start_q;
	logic [TIME_W-1:0] out_end_q;

	// input fields
	func_t              in_func;
	logic [SLOT_W-1:0]  in_slot;
	logic [ARR_W-1:0]   in_arr;
	logic [PRI_W-1:0]   in_pri;
	logic [BURST_W-1:0] in_burst;
	logic               in_accept;
	logic               load_ok;
	logic [IDX_W-1:0]   load_idx;
	logic [COUNT_W-1:0] n_clamp;

	assign in_func  = func_t'(s_axis_tuser);
	assign in_slot  = s_axis_tdata[SLOT_W-1:0];
	assign in_arr   = s_axis_tdata[ARR_LSB +: ARR_W];
	assign in_pri   = s_axis_tdata[PRI_LSB +: PRI_W];
	assign in_burst = s_axis_tdata[BURST_LSB +: BURST_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign load_ok       = int'(in_slot) < MAX_PROCESSES;
	assign load_idx      = IDX_W'(in_slot);
	assign n_clamp       = (proc_count_q > COUNT_W'(SCAN_LIM)) ? COUNT_W'(SCAN_LIM)
	                                                           : proc_count_q;

	assign cfg_ready = 1'b1;

	// value mod AGING_TICKS in two steps
	logic [PROD_W-1:0] mod_prod;
	logic [TIME_W-1:0] mod_quo;
	logic [TIME_W-1:0] mod_back;
	logic [TIME_W-1:0] mod_diff;
	logic [REM_W-1:0]  mod_rem;
	logic              mod_last;

	always_comb begin
		// first step: quotient from the reciprocal product
		mod_prod = PROD_W'(mod_x_q) * PROD_W'(RECIP);
		mod_quo  = TIME_W'(mod_prod >> RECIP_SH);
		// second step: remainder from the registered quotient
		mod_back = mod_quo_q * TIME_W'(AGING_TICKS);
		mod_diff = mod_x_q - mod_back;
		mod_rem  = mod_diff[REM_W-1:0];
	end

	assign mod_last = mod_ph_q;

	// table walk: one slot per cycle
	logic [IDX_W-1:0]  sc_idx;
	logic [TIME_W-1:0] sc_arr;
	logic [PRI_W-1:0]  sc_pri;
	logic              sc_ready;
	logic              sc_age;
	logic [PRI_W-1:0]  sc_eff;
	logic              sc_take;
	logic              sc_future;
	logic              sc_end;

	always_comb begin
		sc_idx   = i_q[IDX_W-1:0];
		sc_arr   = TIME_W'(arr_q[sc_idx]);
		sc_pri   = eff_pri_q[sc_idx];
		sc_ready = !done_q[sc_idx] && (sc_arr <= time_q);
		// a ready process has waited since its arrival tick
		sc_age   = sc_ready && (sc_arr != time_q) && (arr_mod_q[sc_idx] == tmod_q);
		if (!sc_age) begin
			sc_eff = sc_pri;
		end else if (sc_pri > PRI_W'(1)) begin
			sc_eff = sc_pri - PRI_W'(1);
		end else begin
			sc_eff = PRI_W'(1);
		end
		sc_take = sc_ready && (!best_v_q || (sc_eff < best_pri_q) ||
		          ((sc_eff == best_pri_q) && (arr_q[sc_idx] < best_arr_q)));
		sc_future = !done_q[sc_idx] && !sc_ready &&
		            (!next_v_q || (arr_q[sc_idx] < next_arr_q));
		sc_end = (i_q == n_q - COUNT_W'(1));
	end

	// segment decision
	logic              out_free;
	logic              out_load;
	logic [TIME_W-1:0] seg_end;
	logic [TIME_W-1:0] idle_end;
	logic              dec_last;

	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_DECIDE) && (best_v_q || next_v_q) && out_free;
	assign seg_end  = time_q + TIME_W'(best_burst_q);
	assign idle_end = TIME_W'(next_arr_q);
	assign dec_last = (best_v_q && (done_cnt_q + COUNT_W'(1) == n_q)) ||
	                  (k_q + SEG_W'(1) == SEG_W'(MAX_SEGMENTS));

	// slot table payload
	always_ff @(posedge clk) begin
		if (in_accept && (in_func == FUNC_LOAD) && load_ok) begin
			arr_q[load_idx]        <= in_arr;
			loaded_pri_q[load_idx] <= in_pri;
			burst_q[load_idx]      <= in_burst;
		end
		if (in_accept && (in_func == FUNC_START)) begin
			for (int j = 0; j < MAX_PROCESSES; j++) begin
				eff_pri_q[j] <= loaded_pri_q[j];
			end
		end
		if (state_q == ST_SCAN) begin
			eff_pri_q[sc_idx] <= sc_eff;
		end
		if ((state_q == ST_MOD) && mod_last && load_mode_q) begin
			arr_mod_q[load_idx_q] <= mod_rem;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			proc_count_q <= cfg_data;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			done_cnt_q  <= '0;
			i_q         <= '0;
			k_q         <= '0;
			time_q      <= '0;
			best_v_q    <= 1'b0;
			next_v_q    <= 1'b0;
			mod_ph_q    <= 1'b0;
			load_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < MAX_PROCESSES; j++) begin
				done_q[j] <= 1'b0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						unique case (in_func)
							FUNC_LOAD: begin
								if (load_ok) begin
									mod_x_q     <= TIME_W'(in_arr);
									mod_ph_q    <= 1'b0;
									load_mode_q <= 1'b1;
									load_idx_q  <= load_idx;
									state_q     <= ST_MOD;
								end
							end
							FUNC_START: begin
								for (int j = 0; j < MAX_PROCESSES; j++) begin
									done_q[j] <= 1'b0;
								end
								n_q         <= n_clamp;
								done_cnt_q  <= '0;
								k_q         <= '0;
								time_q      <= '0;
								mod_x_q     <= '0;
								mod_ph_q    <= 1'b0;
								load_mode_q <= 1'b0;
								if (n_clamp != '0) begin
									state_q <= ST_MOD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MOD: begin
					if (!mod_ph_q) begin
						mod_quo_q <= mod_quo;
					end
					mod_ph_q <= !mod_ph_q;
					if (mod_last) begin
						if (load_mode_q) begin
							state_q <= ST_IDLE;
						end else begin
							tmod_q   <= mod_rem;
							i_q      <= '0;
							best_v_q <= 1'b0;
							next_v_q <= 1'b0;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (sc_take) begin
						best_v_q     <= 1'b1;
						best_idx_q   <= sc_idx;
						best_pri_q   <= sc_eff;
						best_arr_q   <= arr_q[sc_idx];
						best_burst_q <= burst_q[sc_idx];
					end
					if (sc_future) begin
						next_v_q   <= 1'b1;
						next_arr_q <= arr_q[sc_idx];
					end
					i_q <= i_q + COUNT_W'(1);
					if (sc_end) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!best_v_q && !next_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_idle_q  <= !best_v_q;
						out_last_q  <= dec_last;
						out_start_q <= time_q;
						k_q         <= k_q + SEG_W'(1);
						if (best_v_q) begin
							out_slot_q          <= SLOT_W'(best_idx_q);
							out_end_q           <= seg_end;
							time_q              <= seg_end;
							mod_x_q             <= seg_end;
							done_q[best_idx_q]  <= 1'b1;
							done_cnt_q          <= done_cnt_q + COUNT_W'(1);
						end else begin
							// nothing ready: idle up to the next arrival
							out_slot_q <= '0;
							out_end_q  <= idle_end;
							time_q     <= idle_end;
							mod_x_q    <= idle_end;
						end
						state_q <= dec_last ? ST_IDLE : ST_MOD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_idle_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {OUT_PAD_W'(0), out_end_q, out_start_q, out_slot_q};

endmodule

FILE: test/priority_scheduler_with_aging_core_test.sv
// self-checking testbench for the priority scheduler with aging: loads, runs, segment checks
module priority_scheduler_with_aging_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import psa_pkg::*;

	localparam int RANDOM_ITEMS  = 370;
	localparam int LIMIT_CYCLES  = 2_000_000;
	localparam int HOLD_CYCLES   = 3000;
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_REPORTS   = 40;

	typedef enum logic [1:0] {
		SLOT_NEW,
		SLOT_READY,
		SLOT_DONE
	} slot_state_t;

	typedef struct packed {
		logic              idle;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] t1;
		logic              last;
	} segment_t;

	class schedule_board;
		logic [ARR_W-1:0]   arrival_tab [SLOT_LIMIT];
		logic [PRI_W-1:0]   prio_tab [SLOT_LIMIT];
		logic [BURST_W-1:0] burst_tab [SLOT_LIMIT];
		int unsigned        proc_count;
		segment_t           due [$];
		int                 errors;

		function new();
			proc_count = 0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function void note_input(func_t func, logic [SLOT_W-1:0] slot, logic [ARR_W-1:0] arr,
				logic [PRI_W-1:0] pri, logic [BURST_W-1:0] burst);
			if (func == FUNC_LOAD) begin
				arrival_tab[slot] = arr;
				prio_tab[slot] = pri;
				burst_tab[slot] = burst;
			end else begin
				plan_schedule();
			end
		endfunction

		// whole non-preemptive run from tick 0, one segment per run or idle stretch
		function void plan_schedule();
			int unsigned n, now, done_cnt, waited, fin, nxt, best_pri, best_arr;
			int best;
			bit found;
			int unsigned eff [SLOT_LIMIT];
			int unsigned wait_from [SLOT_LIMIT];
			slot_state_t st [SLOT_LIMIT];
			segment_t seg;
			segment_t plan [$];
			n = (proc_count > SLOT_LIMIT) ? SLOT_LIMIT : proc_count;
			now = 0;
			done_cnt = 0;
			for (int i = 0; i < SLOT_LIMIT; i++) begin
				st[i] = SLOT_NEW;
				eff[i] = prio_tab[i];
				wait_from[i] = 0;
			end
			while (done_cnt < n && plan.size() < MAX_SEGMENTS) begin
				for (int i = 0; i < n; i++)
					if (st[i] == SLOT_NEW && arrival_tab[i] <= now) begin
						st[i] = SLOT_READY;
						wait_from[i] = now;
					end
				// aging only happens here, at a scheduling point
				for (int i = 0; i < n; i++)
					if (st[i] == SLOT_READY) begin
						waited = now - wait_from[i];
						if (waited > 0 && waited % AGING_TICKS_DEF == 0)
							eff[i] = (eff[i] > 1) ? eff[i] - 1 : 1;
					end
				best = -1;
				best_pri = 0;
				best_arr = 0;
				for (int i = 0; i < n; i++)
					if (st[i] == SLOT_READY && (best < 0 || eff[i] < best_pri ||
							(eff[i] == best_pri && arrival_tab[i] < best_arr))) begin
						best = i;
						best_pri = eff[i];
						best_arr = arrival_tab[i];
					end
				if (best < 0) begin
					found = 1'b0;
					nxt = 0;
					for (int i = 0; i < n; i++)
						if (st[i] == SLOT_NEW && (!found || arrival_tab[i] < nxt)) begin
							nxt = arrival_tab[i];
							found = 1'b1;
						end
					if (!found)
						break;
					seg = '{idle: 1'b1, slot: '0, t0: TIME_W'(now), t1: TIME_W'(nxt),
						last: 1'b0};
					plan.insert(plan.size(), seg);
					now = nxt;
				end else begin
					fin = now + burst_tab[best];
					// arrivals during the burst start waiting from their own arrival tick
					for (int i = 0; i < n; i++)
						if (st[i] == SLOT_NEW && arrival_tab[i] < fin) begin
							st[i] = SLOT_READY;
							wait_from[i] = (arrival_tab[i] > now) ? arrival_tab[i] : now;
						end
					st[best] = SLOT_DONE;
					seg = '{idle: 1'b0, slot: SLOT_W'(best), t0: TIME_W'(now), t1: TIME_W'(fin),
						last: 1'b0};
					plan.insert(plan.size(), seg);
					now = fin;
					done_cnt++;
				end
			end
			if (plan.size() > 0)
				plan[plan.size() - 1].last = 1'b1;
			foreach (plan[i])
				due.insert(due.size(), plan[i]);
		endfunction

		task check_segment(segment_t got);
			segment_t want;
			if (due.size() == 0) begin
				report($sformatf("segment with nothing pending: idle %0b slot %0d %0d..%0d last %0b",
					got.idle, got.slot, got.t0, got.t1, got.last));
				return;
			end
			want = due.pop_front();
			if (got.idle !== want.idle || got.slot !== want.slot || got.t0 !== want.t0 ||
					got.t1 !== want.t1 || got.last !== want.last)
				report({$sformatf("got idle %0b slot %0d %0d..%0d last %0b",
						got.idle, got.slot, got.t0, got.t1, got.last),
					$sformatf(", want idle %0b slot %0d %0d..%0d last %0b",
						want.idle, want.slot, want.t0, want.t1, want.last)});
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	schedule_board board = new();
	bit          feed_steady = 1'b0;
	bit          drain_steady = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;

	// crafted table: ties, priority zero, zero burst, far arrivals, widest fields
	int unsigned dir_arr [16] = '{0, 0, 2, 2, 4, 6, 9, 9, 65535, 1000, 1000, 40, 41, 3000, 3, 65535};
	int unsigned dir_pri [16] = '{15, 3, 3, 3, 0, 1, 8, 8, 2, 15, 1, 12, 12, 7, 15, 15};
	int unsigned dir_burst [16] = '{12, 5, 7, 4, 6, 0, 3, 3, 4095, 1, 2, 10, 9, 0, 20, 4095};

	priority_scheduler_with_aging_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("priority_scheduler_with_aging_core_test: done, errors");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (drain_steady || $urandom_range(0, 3) != 0) begin
			m_axis_tready <= 1'b1;
		end else begin
			stall_left = pick_gap();
			m_axis_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin : watch_segments
		segment_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.idle = m_axis_tuser;
			got.slot = m_axis_tdata[SLOT_W-1:0];
			got.t0 = m_axis_tdata[SLOT_W +: TIME_W];
			got.t1 = m_axis_tdata[SLOT_W + TIME_W +: TIME_W];
			got.last = m_axis_tlast;
			board.check_segment(got);
		end
	end

	task automatic push_item(func_t func, logic [SLOT_W-1:0] slot, logic [ARR_W-1:0] arr,
			logic [PRI_W-1:0] pri, logic [BURST_W-1:0] burst);
		int gap;
		logic [IN_DATA_W-1:0] word;
		gap = feed_steady ? 0 : pick_gap();
		word = '0;
		word[SLOT_W-1:0] = slot;
		word[ARR_LSB +: ARR_W] = arr;
		word[PRI_LSB +: PRI_W] = pri;
		word[BURST_LSB +: BURST_W] = burst;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= func;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		board.note_input(func, slot, arr, pri, burst);
	endtask

	// arrivals and bursts mostly clustered so that contention and aging occur
	task automatic push_random(func_t func, int unsigned count);
		logic [SLOT_W-1:0] slot;
		logic [ARR_W-1:0] arr;
		logic [PRI_W-1:0] pri;
		logic [BURST_W-1:0] burst;
		int r;
		int unsigned used;
		used = (count > SLOT_LIMIT) ? SLOT_LIMIT : count;
		if (used > 0 && $urandom_range(0, 99) < 85)
			slot = SLOT_W'($urandom_range(0, used - 1));
		else
			slot = SLOT_W'($urandom_range(0, SLOT_LIMIT - 1));
		r = $urandom_range(0, 99);
		arr = ARR_W'((r < 70) ? $urandom_range(0, 63) : (r < 85) ? $urandom_range(0, 2000)
			: $urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		burst = BURST_W'((r < 75) ? $urandom_range(0, 24) : (r < 90) ? $urandom_range(0, 400)
			: $urandom_range(0, 4095));
		pri = PRI_W'(($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 15));
		push_item(func, slot, arr, pri, burst);
	endtask

	task automatic stop_feed();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// wait for every pending segment, then let a trailing load finish
	task automatic settle();
		stop_feed();
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [COUNT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		board.proc_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent;
		int phase;
		int len;
		int unsigned count;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_LOAD;
		m_axis_tready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		write_count(COUNT_W'(SLOT_LIMIT));
		for (int i = 0; i < SLOT_LIMIT; i++)
			push_item(FUNC_LOAD, SLOT_W'(i), ARR_W'(dir_arr[i]), PRI_W'(dir_pri[i]),
				BURST_W'(dir_burst[i]));
		push_random(FUNC_START, SLOT_LIMIT);
		settle();
		write_count('0);
		push_random(FUNC_START, 0);
		settle();
		// count beyond the table is clamped
		write_count(COUNT_W'(31));
		push_random(FUNC_START, 31);
		push_random(FUNC_START, 31);
		settle();
		write_count(COUNT_W'(1));
		push_random(FUNC_START, 1);

		// random phases: loads with random content, each phase closed by a start
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			feed_steady = ($urandom_range(0, 3) == 0);
			drain_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 70)
				count = $urandom_range(1, 8);
			else if ($urandom_range(0, 99) < 80)
				count = $urandom_range(9, SLOT_LIMIT);
			else
				count = $urandom_range(0, 31);
			if (phase == 1) begin
				// output held off while the sender keeps offering
				count = SLOT_LIMIT;
				feed_steady = 1'b1;
				hold_req = 1'b1;
			end
			write_count(COUNT_W'(count));
			len = $urandom_range(6, 14);
			for (int j = 0; j < len; j++) begin
				if (j == len - 1 || (phase == 1 && j == 0) || $urandom_range(0, 99) < 30)
					push_random(FUNC_START, count);
				else
					push_random(FUNC_LOAD, count);
				sent++;
			end
			phase++;
		end
		settle();
		repeat (200) @(posedge clk);

		if (board.errors == 0)
			$display("priority_scheduler_with_aging_core_test: done, clean");
		else
			$display("priority_scheduler_with_aging_core_test: done, errors");
		$finish;
	end

endmodule
